FILE: rtl/core/cbsw_pkg.sv
// ----------------------------------------------------------------------------
// cbsw_pkg
// Shared types, constants and helpers for the cubic B-spline stencil weights
// ----------------------------------------------------------------------------
package cbsw_pkg;

    // fixed-point constants
    localparam logic [23:0] INV_SPACING_RESET = 24'd65536;
    localparam logic [30:0] RECIP3            = 31'd1431655766; // ceil(2^32 / 3)
    localparam int          STENCIL_LAST      = 63;

    // one particle position
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } cbsw_in_t;

    // one stencil entry
    typedef struct packed {
        logic signed [15:0] node_i;
        logic signed [15:0] node_j;
        logic signed [15:0] node_k;
        logic        [15:0] weight;
        logic signed [23:0] grad_x;
        logic signed [23:0] grad_y;
        logic signed [23:0] grad_z;
        logic               last;
    } cbsw_out_t;

    // per-axis base node, Q0.20 weights and signed Q0.20 derivatives
    typedef struct packed {
        logic signed [24:0] base;
        logic [3:0][19:0]   w;
        logic [3:0][20:0]   d;
    } cbsw_axis_t;

    // one stencil entry before the product pipeline
    typedef struct packed {
        logic signed [15:0] node_i;
        logic signed [15:0] node_j;
        logic signed [15:0] node_k;
        logic        [19:0] wx;
        logic        [19:0] wy;
        logic        [19:0] wz;
        logic signed [20:0] dx;
        logic signed [20:0] dy;
        logic signed [20:0] dz;
        logic               last;
    } cbsw_entry_t;

    // saturate a node index to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
        logic signed [15:0] r;
        if (v > 25'sd32767)
            r = 16'sh7fff;
        else if (v < -25'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/cubic_bspline_stencil_weights.sv
// ----------------------------------------------------------------------------
// cubic_bspline_stencil_weights
// Throughput: one entry per cycle while a particle's entries are emitted, set by the
// stencil sequencer emitting the 4x4x4 entries in turn; a new particle can be
// accepted while the previous one's entries are still emitted.
// busy is high while the axis pipeline or the hold buffer is occupied.
// Reset clears all valid state and sets inv_spacing to 1.0; results cannot
// be stalled.
// ----------------------------------------------------------------------------
module cubic_bspline_stencil_weights (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cbsw_pkg::cbsw_in_t  pos,
    input  logic                cfg_we,
    input  logic [23:0]         cfg_data,
    output logic                result_valid,
    output cbsw_pkg::cbsw_out_t result
);

    logic        [23:0] inv_reg;
    logic               accept;
    logic               vx, vy, vz, fx, fy, fz;
    logic               ax_valid;
    cbsw_pkg::cbsw_axis_t ax_x, ax_y, ax_z;

    // hold buffer and sequencer
    logic               pend_valid_reg;
    cbsw_pkg::cbsw_axis_t pend_x_reg, pend_y_reg, pend_z_reg;
    cbsw_pkg::cbsw_axis_t cur_x_reg, cur_y_reg, cur_z_reg;
    logic [5:0]         cnt_reg;
    logic               run_reg;
    logic               load;
    logic [1:0]         si, sj, sk;

    logic               entry_valid_reg;
    cbsw_pkg::cbsw_entry_t entry_reg;
    cbsw_pkg::cbsw_entry_t entry_next;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inv_reg <= cbsw_pkg::INV_SPACING_RESET;
        else if (cfg_we)
            inv_reg <= cfg_data;
    end

    assign accept = start && !busy;

    // per-axis weight units
    cbsw_axis u_axis_x (.clk(clk), .rst_n(rst_n), .in_valid(accept), .pos(pos.pos_x),
                        .inv_spacing(inv_reg), .out_valid(vx), .in_flight(fx), .axis(ax_x));
    cbsw_axis u_axis_y (.clk(clk), .rst_n(rst_n), .in_valid(accept), .pos(pos.pos_y),
                        .inv_spacing(inv_reg), .out_valid(vy), .in_flight(fy), .axis(ax_y));
    cbsw_axis u_axis_z (.clk(clk), .rst_n(rst_n), .in_valid(accept), .pos(pos.pos_z),
                        .inv_spacing(inv_reg), .out_valid(vz), .in_flight(fz), .axis(ax_z));

    assign ax_valid = vx & vy & vz;
    assign busy     = pend_valid_reg | fx | fy | fz;
    assign load     = pend_valid_reg && (!run_reg || cnt_reg == 6'(cbsw_pkg::STENCIL_LAST));

    // hold buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else if (ax_valid)
            pend_valid_reg <= 1'b1;
        else if (load)
            pend_valid_reg <= 1'b0;
    end

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            run_reg         <= 1'b0;
            entry_valid_reg <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= run_reg;
            if (load)
            begin
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(cbsw_pkg::STENCIL_LAST))
                    run_reg <= 1'b0;
            end
        end
    end

    // stencil entry selection, k innermost
    always_comb
    begin
        si                = cnt_reg[5:4];
        sj                = cnt_reg[3:2];
        sk                = cnt_reg[1:0];
        entry_next.node_i = cbsw_pkg::sat16(cur_x_reg.base + $signed({23'b0, si}));
        entry_next.node_j = cbsw_pkg::sat16(cur_y_reg.base + $signed({23'b0, sj}));
        entry_next.node_k = cbsw_pkg::sat16(cur_z_reg.base + $signed({23'b0, sk}));
        entry_next.wx     = cur_x_reg.w[si];
        entry_next.wy     = cur_y_reg.w[sj];
        entry_next.wz     = cur_z_reg.w[sk];
        entry_next.dx     = cur_x_reg.d[si];
        entry_next.dy     = cur_y_reg.d[sj];
        entry_next.dz     = cur_z_reg.d[sk];
        entry_next.last   = (cnt_reg == 6'(cbsw_pkg::STENCIL_LAST));
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ax_valid)
        begin
            pend_x_reg <= ax_x;
            pend_y_reg <= ax_y;
            pend_z_reg <= ax_z;
        end
        if (load)
        begin
            cur_x_reg <= pend_x_reg;
            cur_y_reg <= pend_y_reg;
            cur_z_reg <= pend_z_reg;
        end
        entry_reg <= entry_next;
    end

    // weight and gradient products
    cbsw_entry u_entry (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (entry_valid_reg),
        .entry       (entry_reg),
        .inv_spacing (inv_reg),
        .out_valid   (result_valid),
        .result      (result)
    );

endmodule

FILE: rtl/core/cbsw_axis.sv
// ----------------------------------------------------------------------------
// cbsw_axis
// Five-stage pipeline: grid position, base node and the four cubic B-spline
// weights and derivatives of one axis
// ----------------------------------------------------------------------------
module cbsw_axis (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [31:0]   pos,
    input  logic [23:0]          inv_spacing,
    output logic                 out_valid,
    output logic                 in_flight,
    output cbsw_pkg::cbsw_axis_t axis
);

    logic [4:0] v_reg;

    // stage 1: scaled position
    logic signed [56:0] prod_reg;
    logic signed [56:0] prod_next;

    // stage 2: fraction, squares, base
    logic [15:0]        f_s2_reg;
    logic [16:0]        g_s2_reg;
    logic [31:0]        f2_s2_reg;
    logic [33:0]        g2_s2_reg;
    logic signed [24:0] base_s2_reg;
    logic [39:0]        gpos;
    logic [15:0]        f_next;
    logic [16:0]        g_next;

    // stage 3: cubes and derivatives
    logic [47:0]        f3_s3_reg;
    logic [48:0]        g3_s3_reg;
    logic [31:0]        f2_s3_reg;
    logic [15:0]        f_s3_reg;
    logic signed [24:0] base_s3_reg;
    logic [3:0][20:0]   d_s3_reg;
    logic [3:0][20:0]   d_next;
    logic [35:0]        f2x3;
    logic signed [35:0] dn [4];
    logic signed [35:0] ds [4];

    // stage 4: weight numerators over 2^29
    logic [3:0][22:0]   y_s4_reg;
    logic [3:0][22:0]   y_next;
    logic signed [24:0] base_s4_reg;
    logic [3:0][20:0]   d_s4_reg;
    logic [52:0]        num [4];
    logic [52:0]        f3x3_w;
    logic [52:0]        f2x3_w;
    logic [52:0]        fx3_w;
    logic [52:0]        nr;

    // stage 5: divide by three
    cbsw_pkg::cbsw_axis_t axis_reg;
    cbsw_pkg::cbsw_axis_t axis_next;
    logic [53:0]          q [4];

    // valid shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[3:0], in_valid};
    end

    assign prod_next = 57'(pos * $signed({1'b0, inv_spacing}));

    always_comb
    begin
        gpos   = prod_reg[55:16];
        f_next = gpos[15:0];
        g_next = 17'h10000 - {1'b0, f_next};
    end

    // derivative numerators, times 2^32
    always_comb
    begin
        f2x3  = {4'b0, f2_s2_reg} + {3'b0, f2_s2_reg, 1'b0};
        dn[0] = -$signed({2'b0, g2_s2_reg});
        dn[1] = $signed(f2x3) - $signed({2'b0, f_s2_reg, 18'b0});
        dn[2] = $signed(36'h1_0000_0000) + $signed({3'b0, f_s2_reg, 17'b0})
                - $signed(f2x3);
        dn[3] = $signed({4'b0, f2_s2_reg});
        for (int n = 0; n < 4; n++)
        begin
            ds[n]     = dn[n] + 36'sd4096;
            d_next[n] = ds[n][33:13];
        end
    end

    // weight numerators, times 6 * 2^48, then rounded over 2^29
    always_comb
    begin
        f3x3_w = {5'b0, f3_s3_reg} + {4'b0, f3_s3_reg, 1'b0};
        f2x3_w = {21'b0, f2_s3_reg} + {20'b0, f2_s3_reg, 1'b0};
        fx3_w  = {37'b0, f_s3_reg} + {36'b0, f_s3_reg, 1'b0};
        num[0] = {4'b0, g3_s3_reg};
        num[1] = f3x3_w - (f2x3_w << 17) + (53'd1 << 50);
        num[2] = (f2x3_w << 16) + (fx3_w << 32) + (53'd1 << 48) - f3x3_w;
        num[3] = {5'b0, f3_s3_reg};
        for (int n = 0; n < 4; n++)
        begin
            nr        = num[n] + (53'd3 << 28);
            y_next[n] = nr[51:29];
        end
    end

    // division by three through the reciprocal
    always_comb
    begin
        axis_next.base = base_s4_reg;
        axis_next.d    = d_s4_reg;
        for (int n = 0; n < 4; n++)
        begin
            q[n]              = 54'(y_s4_reg[n]) * 54'(cbsw_pkg::RECIP3);
            axis_next.w[n]    = q[n][51:32];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        f_s2_reg    <= f_next;
        g_s2_reg    <= g_next;
        f2_s2_reg   <= f_next * f_next;
        g2_s2_reg   <= 34'(g_next * g_next);
        base_s2_reg <= $signed({gpos[39], gpos[39:16]}) - 25'sd1;
        f3_s3_reg   <= 48'(f2_s2_reg * f_s2_reg);
        g3_s3_reg   <= 49'(g2_s2_reg[32:0] * g_s2_reg);
        f2_s3_reg   <= f2_s2_reg;
        f_s3_reg    <= f_s2_reg;
        base_s3_reg <= base_s2_reg;
        d_s3_reg    <= d_next;
        y_s4_reg    <= y_next;
        base_s4_reg <= base_s3_reg;
        d_s4_reg    <= d_s3_reg;
        axis_reg    <= axis_next;
    end

    assign out_valid = v_reg[4];
    assign in_flight = |v_reg;
    assign axis      = axis_reg;

endmodule

FILE: rtl/core/cbsw_entry.sv
// ----------------------------------------------------------------------------
// cbsw_entry
// Five-stage product pipeline: weight and gradient of one stencil entry
// ----------------------------------------------------------------------------
module cbsw_entry (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  cbsw_pkg::cbsw_entry_t entry,
    input  logic [23:0]           inv_spacing,
    output logic                  out_valid,
    output cbsw_pkg::cbsw_out_t   result
);

    logic [4:0] v_reg;

    // stage 1: pair products
    cbsw_pkg::cbsw_entry_t e1_reg;
    logic [39:0] wyz_reg;
    logic [39:0] wxz_reg;
    logic [39:0] wxy_reg;

    // stage 2: triple products
    cbsw_pkg::cbsw_entry_t e2_reg;
    logic [59:0]        p_reg;
    logic signed [61:0] gx_reg;
    logic signed [61:0] gy_reg;
    logic signed [61:0] gz_reg;

    // stage 3: rounding, weight to Q0.16 and gradients to Q0.20
    cbsw_pkg::cbsw_entry_t e3_reg;
    logic [15:0]        wt3_reg;
    logic signed [21:0] tx_reg;
    logic signed [21:0] ty_reg;
    logic signed [21:0] tz_reg;
    logic [59:0]        pr;
    logic signed [61:0] gxr;
    logic signed [61:0] gyr;
    logic signed [61:0] gzr;

    // stage 4: scale by inverse spacing
    cbsw_pkg::cbsw_entry_t e4_reg;
    logic [15:0]        wt4_reg;
    logic signed [46:0] rx_reg;
    logic signed [46:0] ry_reg;
    logic signed [46:0] rz_reg;

    // stage 5: final rounding
    cbsw_pkg::cbsw_out_t out_reg;
    cbsw_pkg::cbsw_out_t out_next;
    logic signed [46:0]  rxr;
    logic signed [46:0]  ryr;
    logic signed [46:0]  rzr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[3:0], in_valid};
    end

    always_comb
    begin
        pr  = p_reg + (60'd1 << 43);
        gxr = gx_reg + (62'sd1 <<< 39);
        gyr = gy_reg + (62'sd1 <<< 39);
        gzr = gz_reg + (62'sd1 <<< 39);
    end

    always_comb
    begin
        rxr             = rx_reg + 47'sd524288;
        ryr             = ry_reg + 47'sd524288;
        rzr             = rz_reg + 47'sd524288;
        out_next.node_i = e4_reg.node_i;
        out_next.node_j = e4_reg.node_j;
        out_next.node_k = e4_reg.node_k;
        out_next.weight = wt4_reg;
        out_next.grad_x = rxr[43:20];
        out_next.grad_y = ryr[43:20];
        out_next.grad_z = rzr[43:20];
        out_next.last   = e4_reg.last;
    end

    always_ff @(posedge clk)
    begin
        e1_reg  <= entry;
        wyz_reg <= entry.wy * entry.wz;
        wxz_reg <= entry.wx * entry.wz;
        wxy_reg <= entry.wx * entry.wy;

        e2_reg  <= e1_reg;
        p_reg   <= 60'(e1_reg.wx * wyz_reg);
        gx_reg  <= 62'(e1_reg.dx * $signed({1'b0, wyz_reg}));
        gy_reg  <= 62'(e1_reg.dy * $signed({1'b0, wxz_reg}));
        gz_reg  <= 62'(e1_reg.dz * $signed({1'b0, wxy_reg}));

        e3_reg  <= e2_reg;
        wt3_reg <= pr[59:44];
        tx_reg  <= gxr[61:40];
        ty_reg  <= gyr[61:40];
        tz_reg  <= gzr[61:40];

        e4_reg  <= e3_reg;
        wt4_reg <= wt3_reg;
        rx_reg  <= 47'(tx_reg * $signed({1'b0, inv_spacing}));
        ry_reg  <= 47'(ty_reg * $signed({1'b0, inv_spacing}));
        rz_reg  <= 47'(tz_reg * $signed({1'b0, inv_spacing}));

        out_reg <= out_next;
    end

    assign out_valid = v_reg[4];
    assign result    = out_reg;

endmodule

FILE: rtl/core/cbsw_check.sv
// ----------------------------------------------------------------------------
// cbsw_check
// Port-level checks on transaction acceptance and stencil result bursts
// ----------------------------------------------------------------------------
module cbsw_check (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                result_valid,
    input cbsw_pkg::cbsw_out_t result
);

    // an accepted transaction occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy low after accepted transaction");

    // stencil entries of one particle come without gaps
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid)
        else $error("gap inside a stencil burst");

    // the last entry closes a burst of 64
    a_last_len: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> $past(result_valid, 63))
        else $error("last entry without a full burst");

    // inside a burst, a node k saturated at -32768 is followed by one in -32768 to -32765
    a_k_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last && result.node_k == -16'sd32768
        |=> result.node_k == -16'sd32768 || result.node_k == -16'sd32767
            || result.node_k == -16'sd32766 || result.node_k == -16'sd32765)
        else $error("node k out of stencil range");

endmodule

bind cubic_bspline_stencil_weights cbsw_check u_cbsw_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
